// ===== sv/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg: shared types, constants and tables of the frame sender
// Request codes, driver command bytes, fonts, grid mapping tables and the
// grid word builder used by the front and back parts.
// ----------------------------------------------------------------------------
package ssg_pkg;

   localparam int DIGIT_COUNT = 5;
   localparam int GRID_COUNT  = 7;
   localparam int GLYPH_COUNT = 21;

   // request codes on req_type
   typedef enum logic [2:0] {
      REQ_SEGMENT   = 3'd0,
      REQ_GLYPH     = 3'd1,
      REQ_CLEAR     = 3'd2,
      REQ_KEY_START = 3'd3,
      REQ_KEY_BYTE  = 3'd4
   } req_kind_type;

   // register indexes on the csr port
   localparam logic [2:0] CSR_BRIGHTNESS = 3'd0;
   localparam logic [2:0] CSR_DISPLAY_ON = 3'd1;
   localparam logic [2:0] CSR_INVERTED   = 3'd2;
   localparam logic [2:0] CSR_GRID_MODE  = 3'd3;

   // driver command bytes
   localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
   localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
   localparam logic [7:0] CMD_CONTROL    = 8'h80;
   localparam logic [7:0] CMD_MODE       = 8'h00;
   localparam logic [7:0] CMD_KEY_READ   = 8'h42;

   // steps of a refresh
   localparam logic [3:0] STEP_DATA_CMD   = 4'd0;
   localparam logic [3:0] STEP_ADDR_CMD   = 4'd1;
   localparam logic [3:0] STEP_GRID_FIRST = 4'd2;
   localparam logic [3:0] STEP_GRID_LAST  = 4'd8;
   localparam logic [3:0] STEP_MODE_CMD   = 4'd9;
   localparam logic [3:0] STEP_CTRL_CMD   = 4'd10;

   // key byte index that closes a scan
   localparam logic [2:0] KEY_LAST_INDEX = 3'd4;
   // digit carrying the symbol segments
   localparam logic [2:0] SYM_DIGIT = 3'd4;

   typedef logic [DIGIT_COUNT-1:0][7:0] seg_store_type;

   typedef struct packed {
      logic [2:0] brightness_level;
      logic       display_on;
      logic       inverted_orientation;
      logic [1:0] grid_mode;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_REFRESH    = 2'd0,
      JOB_KEY_START  = 2'd1,
      JOB_KEY_RESULT = 2'd2
   } job_kind_type;

   // one job handed from front to back
   typedef struct packed {
      job_kind_type  kind;
      seg_store_type segs;
      logic [25:0]   buttons;
   } job_type;

   // one result word
   typedef struct packed {
      logic [15:0] word;
      logic        word_is_16;
      logic        frame_begin;
      logic        frame_end;
      logic [25:0] buttons;
      logic        buttons_valid;
      logic        last;
   } rsp_type;

   // normal and rotated fonts
   localparam logic [7:0] FONT [2][GLYPH_COUNT] = '{
      '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h77,
        8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h00, 8'h40, 8'h63, 8'h39, 8'h53},
      '{8'h3F, 8'h30, 8'h5B, 8'h79, 8'h74, 8'h6D, 8'h6F, 8'h38, 8'h7F, 8'h7D, 8'h7E,
        8'h67, 8'h43, 8'h4B, 8'h4F, 8'h4E, 8'h00, 8'h40, 8'h5C, 8'h0F, 8'h5A}
   };

   // segment used by the four digit columns, per grid
   localparam logic [2:0] COL_SEG [2][GRID_COUNT] = '{
      '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd6, 3'd0},
      '{3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd3}
   };
   // symbol digit segment on SG3, per grid
   localparam logic [2:0] SYM_SEG [2][GRID_COUNT] = '{
      '{3'd6, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd5},
      '{3'd6, 3'd5, 3'd0, 3'd1, 3'd3, 3'd4, 3'd2}
   };
   // digit feeding SG2, SG8, SG9, SG10
   localparam logic [2:0] COL_DIGIT [2][4] = '{
      '{3'd0, 3'd3, 3'd1, 3'd2},
      '{3'd3, 3'd0, 3'd2, 3'd1}
   };
   localparam logic [3:0] COL_BIT [4] = '{4'd1, 4'd7, 4'd8, 4'd9};
   localparam logic [3:0] SYM_BIT = 4'd2;

   // grid word for one grid line
   function automatic logic [15:0] grid_word(input seg_store_type segs, input logic orient,
                                             input logic [2:0] grid);
      logic [15:0] w;
      logic [7:0]  d;
      w = '0;
      for (int c = 0; c < 4; c++) begin
         d = segs[COL_DIGIT[orient][c]];
         w[COL_BIT[c]] = d[COL_SEG[orient][grid]];
      end
      d = segs[SYM_DIGIT];
      w[SYM_BIT] = d[SYM_SEG[orient][grid]];
      return w;
   endfunction

endpackage

// ===== sv/ssg_front.sv =====
// ----------------------------------------------------------------------------
// ssg_front: request decoder
// Takes requests, updates the segment store and key accumulator, and hands
// a job with a snapshot of the store to the back part.
// ----------------------------------------------------------------------------
module ssg_front import ssg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        accept,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_position,
   input  logic [7:0]  req_value,
   output logic        job_push,
   output job_type     job_data
);

   seg_store_type seg_ff, seg_in;
   logic [25:0]   acc_ff, acc_in;
   logic          pos_ok;
   logic [7:0]    glyph;
   logic [1:0]    k1, k2;
   logic [25:0]   fold;

   // glyph lookup, codes past the font show blank
   always_comb begin
      if (req_value <= 8'(GLYPH_COUNT - 1)) begin
         glyph = FONT[cfg.inverted_orientation][req_value[4:0]];
      end else begin
         glyph = '0;
      end
   end

   // key byte fold, K2 pairs sit sixteen bits above the K1 pairs
   always_comb begin
      k1   = {req_value[3], req_value[0]};
      k2   = {req_value[4], req_value[1]};
      fold = ({24'd0, k1} << {req_position, 1'b0}) |
             ({24'd0, k2} << ({1'b0, req_position, 1'b0} + 5'd16));
   end

   assign pos_ok = (req_position < 3'(DIGIT_COUNT));

   // request decode
   always_comb begin
      seg_in   = seg_ff;
      acc_in   = acc_ff;
      job_push = 1'b0;
      job_data = '{kind: JOB_REFRESH, segs: seg_ff, buttons: '0};
      if (accept) begin
         unique case (req_kind_type'(req_type))
            REQ_SEGMENT: begin
               if (pos_ok) begin
                  seg_in[req_position] = req_value;
                  job_push = 1'b1;
               end
            end
            REQ_GLYPH: begin
               if (pos_ok) begin
                  seg_in[req_position] = glyph;
                  job_push = 1'b1;
               end
            end
            REQ_CLEAR: begin
               seg_in   = '0;
               job_push = 1'b1;
            end
            REQ_KEY_START: begin
               acc_in        = '0;
               job_push      = 1'b1;
               job_data.kind = JOB_KEY_START;
            end
            REQ_KEY_BYTE: begin
               if (req_position <= KEY_LAST_INDEX) begin
                  acc_in = acc_ff | fold;
                  if (req_position == KEY_LAST_INDEX) begin
                     job_push         = 1'b1;
                     job_data.kind    = JOB_KEY_RESULT;
                     job_data.buttons = acc_ff | fold;
                     acc_in           = '0;
                  end
               end
            end
            default: begin
            end
         endcase
         job_data.segs = seg_in;
      end
   end

   // store and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
         acc_ff <= '0;
      end else begin
         seg_ff <= seg_in;
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== sv/ssg_job_queue.sv =====
// ----------------------------------------------------------------------------
// ssg_job_queue: two-entry job queue
// Decouples the request decoder from the word sequencer.
// ----------------------------------------------------------------------------
module ssg_job_queue import ssg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_en,
   input  job_type push_data,
   output logic    full,
   input  logic    pop_en,
   output job_type pop_data,
   output logic    empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push_en && !full;
   assign do_pop   = pop_en && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/ssg_back.sv =====
// ----------------------------------------------------------------------------
// ssg_back: word sequencer
// Steps through the words of each job into a two-entry output buffer that
// feeds the result ports, one word a cycle while that buffer has room.
// ----------------------------------------------------------------------------
module ssg_back import ssg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_empty,
   input  job_type job_data,
   output logic    job_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp
);

   job_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic       emit, at_end, finish;
   rsp_type    word;
   logic [3:0] grid_step;

   rsp_type    out_ff [2];
   logic       out_wr_ff, out_wr_in;
   logic       out_rd_ff, out_rd_in;
   logic [1:0] out_count_ff, out_count_in;
   logic       out_pop;

   // sequencing control
   always_comb begin
      emit    = busy_ff && (out_count_ff != 2'd2);
      at_end  = (cur_ff.kind != JOB_REFRESH) || (step_ff == STEP_CTRL_CMD);
      finish  = emit && at_end;
      job_pop = !job_empty && (!busy_ff || finish);
      cur_in  = job_pop ? job_data : cur_ff;
      if (job_pop) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
      if (job_pop) begin
         step_in = STEP_DATA_CMD;
      end else if (emit) begin
         step_in = step_ff + 4'd1;
      end else begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_DATA_CMD;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // word for the current step
   assign grid_step = step_ff - STEP_GRID_FIRST;

   always_comb begin
      word = '0;
      unique case (cur_ff.kind)
         JOB_REFRESH: begin
            priority if (step_ff == STEP_DATA_CMD) begin
               word.word        = {8'd0, CMD_DATA_WRITE};
               word.frame_begin = 1'b1;
               word.frame_end   = 1'b1;
            end else if (step_ff == STEP_ADDR_CMD) begin
               word.word        = {8'd0, CMD_ADDRESS};
               word.frame_begin = 1'b1;
            end else if (step_ff <= STEP_GRID_LAST) begin
               word.word       = grid_word(cur_ff.segs, cfg.inverted_orientation,
                                           grid_step[2:0]);
               word.word_is_16 = 1'b1;
               word.frame_end  = (step_ff == STEP_GRID_LAST);
            end else if (step_ff == STEP_MODE_CMD) begin
               word.word        = {8'd0, CMD_MODE | {6'd0, cfg.grid_mode}};
               word.frame_begin = 1'b1;
               word.frame_end   = 1'b1;
            end else begin
               word.word        = {8'd0, CMD_CONTROL |
                                   {4'd0, cfg.display_on, cfg.brightness_level}};
               word.frame_begin = 1'b1;
               word.frame_end   = 1'b1;
               word.last        = 1'b1;
            end
         end
         JOB_KEY_START: begin
            word.word        = {8'd0, CMD_KEY_READ};
            word.frame_begin = 1'b1;
            word.last        = 1'b1;
         end
         JOB_KEY_RESULT: begin
            word.frame_end     = 1'b1;
            word.buttons       = cur_ff.buttons;
            word.buttons_valid = 1'b1;
            word.last          = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // output buffer
   assign empty   = (out_count_ff == 2'd0);
   assign rsp     = out_ff[out_rd_ff];
   assign out_pop = pop && !empty;

   always_comb begin
      out_wr_in    = emit ? ~out_wr_ff : out_wr_ff;
      out_rd_in    = out_pop ? ~out_rd_ff : out_rd_ff;
      out_count_in = out_count_ff + 2'(emit) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff[out_wr_ff] <= word;
      end
   end

endmodule

// ===== sv/seven_segment_grid_frame_sender_top.sv =====
// ----------------------------------------------------------------------------
// seven_segment_grid_frame_sender_top: grid display frame sender
// A request's first word reaches the result ports via the job queue and the
// sequencer's output buffer. The sequencer gives one word a cycle while the
// buffer has room: a refresh is eleven words, a key read start or scan one.
// Reset clears the segment store, key accumulator and all queues, and sets
// brightness 0, display off, normal orientation and grid mode 3.
// ----------------------------------------------------------------------------
module seven_segment_grid_frame_sender_top import ssg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_position,
   input  logic [7:0]  req_value,
   // result side
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_word,
   output logic        rsp_word_is_16,
   output logic        rsp_frame_begin,
   output logic        rsp_frame_end,
   output logic [25:0] rsp_buttons,
   output logic        rsp_buttons_valid,
   output logic        rsp_last,
   // register port
   input  logic        valid,
   output logic        ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_out;
   rsp_type rsp;

   // register writes
   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: cfg_in.brightness_level     = csr_data[2:0];
            CSR_DISPLAY_ON: cfg_in.display_on           = csr_data[0];
            CSR_INVERTED:   cfg_in.inverted_orientation = csr_data[0];
            CSR_GRID_MODE:  cfg_in.grid_mode            = csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{brightness_level: 3'd0, display_on: 1'b0,
                     inverted_orientation: 1'b0, grid_mode: 2'd3};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request acceptance
   assign full   = job_full;
   assign accept = push && !job_full;

   ssg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .accept       (accept),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .job_push     (job_push),
      .job_data     (job_in)
   );

   ssg_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop_en    (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   ssg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_out),
      .job_pop   (job_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   // result word fields
   assign rsp_word          = rsp.word;
   assign rsp_word_is_16    = rsp.word_is_16;
   assign rsp_frame_begin   = rsp.frame_begin;
   assign rsp_frame_end     = rsp.frame_end;
   assign rsp_buttons       = rsp.buttons;
   assign rsp_buttons_valid = rsp.buttons_valid;
   assign rsp_last          = rsp.last;

endmodule

// ===== sv/ssg_checker.sv =====
// ----------------------------------------------------------------------------
// ssg_checker: port level checks of the frame sender
// Watches the result port for word consistency over time.
// ----------------------------------------------------------------------------
module ssg_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_word,
   input logic        rsp_word_is_16,
   input logic        rsp_frame_begin,
   input logic        rsp_last,
   input logic [25:0] rsp_buttons,
   input logic        rsp_buttons_valid
);

   // nothing waits right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   // a waiting word stays until taken
   a_word_held: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty)
      else $error("waiting word dropped");

   // key scan word carries no command and closes its request
   a_scan_word: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_buttons_valid |-> rsp_word == 16'd0 && rsp_last && !rsp_word_is_16)
      else $error("malformed key scan word");

   // buttons only on the key scan word
   a_buttons_clear: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_buttons_valid |-> rsp_buttons == 26'd0)
      else $error("buttons set outside key scan");

   // grid words sit inside a frame and never end a request
   a_grid_word: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_word_is_16 |-> !rsp_frame_begin && !rsp_last)
      else $error("grid word opens a frame or ends a request");

endmodule

bind seven_segment_grid_frame_sender_top ssg_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .empty             (empty),
   .pop               (pop),
   .rsp_word          (rsp_word),
   .rsp_word_is_16    (rsp_word_is_16),
   .rsp_frame_begin   (rsp_frame_begin),
   .rsp_last          (rsp_last),
   .rsp_buttons       (rsp_buttons),
   .rsp_buttons_valid (rsp_buttons_valid)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the seven-segment grid frame sender
// Drives segment, glyph, clear and key scan requests through the request
// queue, predicts every word of each refresh and key scan from its own copy
// of the digit store, key bits and registers, and checks every popped word
// field by field. Sender bursts, receiver stalls and a long receiver
// hold-off vary the timing while registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import ssg_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int PRINT_LIMIT    = 40;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 20;

   localparam int DIGITS      = 5;
   localparam int GRID_LINES  = 7;
   localparam int LAST_GLYPH  = 20;
   localparam int KEY_CLOSE   = 4;
   localparam int SYMBOL_DIG  = 4;
   localparam int SYMBOL_BIT  = 2;

   // request and register codes the block ignores
   localparam int REQ_UNUSED_FIRST = 5;
   localparam int REQ_UNUSED_LAST  = 7;
   localparam int CSR_UNUSED_FIRST = 4;
   localparam int CSR_UNUSED_LAST  = 7;

   // command bytes of the driver
   localparam logic [7:0] OP_WRITE_DATA   = 8'h40;
   localparam logic [7:0] OP_SET_ADDRESS  = 8'hC0;
   localparam logic [7:0] OP_MODE_BASE    = 8'h00;
   localparam logic [7:0] OP_CONTROL_BASE = 8'h80;
   localparam logic [7:0] OP_READ_KEYS    = 8'h42;

   // upright and rotated font
   localparam logic [7:0] GLYPH_FONT [2][21] = '{
      '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h77,
        8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h00, 8'h40, 8'h63, 8'h39, 8'h53},
      '{8'h3F, 8'h30, 8'h5B, 8'h79, 8'h74, 8'h6D, 8'h6F, 8'h38, 8'h7F, 8'h7D, 8'h7E,
        8'h67, 8'h43, 8'h4B, 8'h4F, 8'h4E, 8'h00, 8'h40, 8'h5C, 8'h0F, 8'h5A}
   };
   // grid line mapping, upright and rotated
   localparam int COLUMN_SEG [2][7]   = '{'{5, 4, 3, 2, 1, 6, 0}, '{2, 1, 0, 5, 4, 6, 3}};
   localparam int SYMBOL_SEG [2][7]   = '{'{6, 2, 3, 4, 0, 1, 5}, '{6, 5, 0, 1, 3, 4, 2}};
   localparam int COLUMN_DIGIT [2][4] = '{'{0, 3, 1, 2}, '{3, 0, 2, 1}};
   localparam int COLUMN_BIT [4]      = '{1, 7, 8, 9};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_type = '0;
   logic [2:0]  req_position = '0;
   logic [7:0]  req_value = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [15:0] rsp_word;
   logic        rsp_word_is_16;
   logic        rsp_frame_begin;
   logic        rsp_frame_end;
   logic [25:0] rsp_buttons;
   logic        rsp_buttons_valid;
   logic        rsp_last;
   logic        valid = 1'b0;
   logic        ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   seven_segment_grid_frame_sender_top dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_type(req_type), .req_position(req_position), .req_value(req_value),
      .empty(empty), .pop(pop),
      .rsp_word(rsp_word), .rsp_word_is_16(rsp_word_is_16),
      .rsp_frame_begin(rsp_frame_begin), .rsp_frame_end(rsp_frame_end),
      .rsp_buttons(rsp_buttons), .rsp_buttons_valid(rsp_buttons_valid),
      .rsp_last(rsp_last),
      .valid(valid), .ready(ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predicted display and key state
   logic [7:0]  digits [DIGITS];
   logic [31:0] key_bits;
   logic [2:0]  brightness;
   logic        display_enable;
   logic        flipped;
   logic [1:0]  mode_code;
   rsp_type     expected_words [$];

   int  mismatches = 0;
   int  words_seen = 0;
   int  burst_left = 0;
   bit  push_high = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  rx_cycle = 0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at word %0d: %s", words_seen, msg);
      mismatches++;
   endtask

   function automatic rsp_type frame_word(input logic [15:0] w, input logic is16,
                                          input logic fb, input logic fe,
                                          input logic [25:0] btn, input logic bv,
                                          input logic lst);
      rsp_type r;
      r.word          = w;
      r.word_is_16    = is16;
      r.frame_begin   = fb;
      r.frame_end     = fe;
      r.buttons       = btn;
      r.buttons_valid = bv;
      r.last          = lst;
      return r;
   endfunction

   // eleven words of a full display refresh
   task automatic queue_refresh();
      logic [15:0] gw;
      int          o;
      o = flipped;
      expected_words.push_back(frame_word({8'h00, OP_WRITE_DATA}, 1'b0, 1'b1, 1'b1,
                                          '0, 1'b0, 1'b0));
      expected_words.push_back(frame_word({8'h00, OP_SET_ADDRESS}, 1'b0, 1'b1, 1'b0,
                                          '0, 1'b0, 1'b0));
      for (int g = 0; g < GRID_LINES; g++) begin
         gw = '0;
         for (int c = 0; c < 4; c++)
            gw[COLUMN_BIT[c]] = digits[COLUMN_DIGIT[o][c]][COLUMN_SEG[o][g]];
         gw[SYMBOL_BIT] = digits[SYMBOL_DIG][SYMBOL_SEG[o][g]];
         expected_words.push_back(frame_word(gw, 1'b1, 1'b0, g == GRID_LINES - 1,
                                             '0, 1'b0, 1'b0));
      end
      expected_words.push_back(frame_word({8'h00, OP_MODE_BASE | {6'b0, mode_code}},
                                           1'b0, 1'b1, 1'b1, '0, 1'b0, 1'b0));
      expected_words.push_back(frame_word({8'h00, OP_CONTROL_BASE |
                                           {4'b0, display_enable, brightness}},
                                           1'b0, 1'b1, 1'b1, '0, 1'b0, 1'b1));
   endtask

   // state update and expected words for one accepted request
   task automatic apply_request(input logic [2:0] kind, input logic [2:0] pos,
                                input logic [7:0] val);
      case (kind)
         REQ_SEGMENT: begin
            if (pos < DIGITS) begin
               digits[pos] = val;
               queue_refresh();
            end
         end
         REQ_GLYPH: begin
            if (pos < DIGITS) begin
               digits[pos] = (val <= LAST_GLYPH) ? GLYPH_FONT[flipped][val[4:0]] : 8'h00;
               queue_refresh();
            end
         end
         REQ_CLEAR: begin
            foreach (digits[i]) digits[i] = 8'h00;
            queue_refresh();
         end
         REQ_KEY_START: begin
            key_bits = '0;
            expected_words.push_back(frame_word({8'h00, OP_READ_KEYS}, 1'b0, 1'b1, 1'b0,
                                                '0, 1'b0, 1'b1));
         end
         REQ_KEY_BYTE: begin
            if (pos <= KEY_CLOSE) begin
               key_bits |= ({30'b0, val[3], val[0]} << (2 * pos))
                         | ({30'b0, val[4], val[1]} << (2 * pos + 16));
               if (pos == KEY_CLOSE) begin
                  expected_words.push_back(frame_word('0, 1'b0, 1'b0, 1'b1,
                                                      key_bits[25:0], 1'b1, 1'b1));
                  key_bits = '0;
               end
            end
         end
         default: ;
      endcase
   endtask

   // compare one popped word with the oldest prediction
   task automatic check_word();
      rsp_type want;
      if (expected_words.size() == 0) begin
         report_error($sformatf("word %h popped with nothing predicted", rsp_word));
      end else begin
         want = expected_words.pop_front();
         if (rsp_word !== want.word)
            report_error($sformatf("word %h, predicted %h", rsp_word, want.word));
         if (rsp_word_is_16 !== want.word_is_16)
            report_error($sformatf("word_is_16 %b, predicted %b",
                                   rsp_word_is_16, want.word_is_16));
         if (rsp_frame_begin !== want.frame_begin)
            report_error($sformatf("frame_begin %b, predicted %b",
                                   rsp_frame_begin, want.frame_begin));
         if (rsp_frame_end !== want.frame_end)
            report_error($sformatf("frame_end %b, predicted %b",
                                   rsp_frame_end, want.frame_end));
         if (rsp_buttons !== want.buttons)
            report_error($sformatf("buttons %h, predicted %h", rsp_buttons, want.buttons));
         if (rsp_buttons_valid !== want.buttons_valid)
            report_error($sformatf("buttons_valid %b, predicted %b",
                                   rsp_buttons_valid, want.buttons_valid));
         if (rsp_last !== want.last)
            report_error($sformatf("last %b, predicted %b", rsp_last, want.last));
      end
      words_seen++;
   endtask

   // receiver: checks each popped word, stalls on a pattern and on request
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty)
            check_word();
         rx_cycle++;
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            case ((rx_cycle / 89) % 4)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= (rx_cycle % 5 == 0);
               default: pop <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic lower_push();
      if (push_high) begin
         push <= 1'b0;
         push_high = 1'b0;
      end
   endtask

   // offer one request and wait until it is taken
   task automatic send_item(input logic [2:0] kind, input logic [2:0] pos,
                            input logic [7:0] val);
      if (burst_left == 0) begin
         lower_push();
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      push <= 1'b1;
      push_high = 1'b1;
      req_type <= kind;
      req_position <= pos;
      req_value <= val;
      @(posedge clock);
      while (full) @(posedge clock);
      apply_request(kind, pos, val);
      burst_left--;
   endtask

   // let every predicted word drain, then allow for a word still in flight
   task automatic wait_idle();
      lower_push();
      burst_left = 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
      valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      case (index)
         CSR_BRIGHTNESS: brightness = data[2:0];
         CSR_DISPLAY_ON: display_enable = data[0];
         CSR_INVERTED:   flipped = data[0];
         CSR_GRID_MODE:  mode_code = data[1:0];
         default: ;
      endcase
   endtask

   // all registers, plus one unused index, written while idle
   task automatic apply_settings(input logic [7:0] bright, input logic [7:0] on_bit,
                                 input logic [7:0] flip, input logic [7:0] mode);
      wait_idle();
      write_reg(3'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)), 8'($urandom));
      write_reg(CSR_BRIGHTNESS, bright);
      write_reg(CSR_DISPLAY_ON, on_bit);
      write_reg(CSR_INVERTED, flip);
      write_reg(CSR_GRID_MODE, mode);
      valid <= 1'b0;
   endtask

   // field extremes, every request kind and the ignored cases, reset settings
   task automatic test_directed_cases();
      send_item(REQ_SEGMENT, 3'd0, 8'hFF);
      send_item(REQ_SEGMENT, 3'd4, 8'hFF);
      send_item(REQ_SEGMENT, 3'd1, 8'h55);
      send_item(REQ_SEGMENT, 3'd2, 8'hAA);
      send_item(REQ_SEGMENT, 3'd3, 8'h80);
      send_item(REQ_GLYPH, 3'd0, 8'd0);
      send_item(REQ_GLYPH, 3'd1, 8'd20);
      send_item(REQ_GLYPH, 3'd2, 8'd21);
      send_item(REQ_GLYPH, 3'd3, 8'd255);
      send_item(REQ_GLYPH, 3'd4, 8'd8);
      // segment and glyph positions past the last digit are dropped
      send_item(REQ_SEGMENT, 3'd5, 8'hFF);
      send_item(REQ_GLYPH, 3'd7, 8'd3);
      send_item(REQ_CLEAR, 3'd7, 8'hFF);
      // complete key scan
      send_item(REQ_KEY_START, 3'd0, 8'h00);
      send_item(REQ_KEY_BYTE, 3'd0, 8'hFF);
      send_item(REQ_KEY_BYTE, 3'd1, 8'h00);
      send_item(REQ_KEY_BYTE, 3'd2, 8'h1B);
      send_item(REQ_KEY_BYTE, 3'd3, 8'hFF);
      send_item(REQ_KEY_BYTE, 3'd7, 8'hFF);
      send_item(REQ_KEY_BYTE, 3'd4, 8'h12);
      // closing key byte with no scan started
      send_item(REQ_KEY_BYTE, 3'd4, 8'hFF);
      send_item(3'(REQ_UNUSED_FIRST), 3'd7, 8'hFF);
      send_item(3'd6, 3'd0, 8'h00);
      send_item(3'(REQ_UNUSED_LAST), 3'd4, 8'hFF);
      send_item(REQ_SEGMENT, 3'd4, 8'h00);
   endtask

   // register extremes and mixed settings, glyphs in both orientations
   task automatic test_register_sweep();
      logic [7:0] sets [4][4];
      sets = '{'{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd7, 8'd1, 8'd1, 8'd3},
               '{8'hFD, 8'hFE, 8'hF0, 8'hFE}, '{8'd2, 8'd0, 8'd1, 8'd1}};
      for (int s = 0; s < 4; s++) begin
         apply_settings(sets[s][0], sets[s][1], sets[s][2], sets[s][3]);
         for (int i = 0; i < 3; i++)
            send_item(REQ_GLYPH, 3'($urandom_range(0, DIGITS - 1)),
                      8'($urandom_range(0, LAST_GLYPH)));
         send_item(REQ_SEGMENT, 3'($urandom_range(0, DIGITS - 1)), 8'($urandom));
      end
   endtask

   // mostly refreshes and well-formed key scans, some broken scans and noise
   task automatic test_random_traffic();
      int counted;
      int pick;
      int n;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               send_item(REQ_SEGMENT, 3'($urandom_range(0, DIGITS - 1)), 8'($urandom));
               counted++;
            end else if (pick < 45) begin
               send_item(REQ_GLYPH, 3'($urandom_range(0, DIGITS - 1)),
                         ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, LAST_GLYPH)));
               counted++;
            end else if (pick < 52) begin
               send_item(REQ_CLEAR, 3'($urandom), 8'($urandom));
               counted++;
            end else if (pick < 78) begin
               send_item(REQ_KEY_START, 3'($urandom), 8'($urandom));
               for (int k = 0; k <= KEY_CLOSE; k++)
                  send_item(REQ_KEY_BYTE, 3'(k), 8'($urandom));
               counted += 6;
            end else if (pick < 88) begin
               // scan cut short, or key bytes with no start
               if ($urandom_range(0, 1) == 1) begin
                  send_item(REQ_KEY_START, 3'($urandom), 8'($urandom));
                  counted++;
               end
               n = $urandom_range(1, 3);
               for (int k = 0; k < n; k++)
                  send_item(REQ_KEY_BYTE, 3'($urandom_range(0, KEY_CLOSE)), 8'($urandom));
               counted += n;
            end else begin
               case ($urandom_range(0, 3))
                  0: send_item(REQ_SEGMENT, 3'($urandom_range(DIGITS, 7)), 8'($urandom));
                  1: send_item(REQ_GLYPH, 3'($urandom_range(DIGITS, 7)), 8'($urandom));
                  2: send_item(REQ_KEY_BYTE, 3'($urandom_range(KEY_CLOSE + 1, 7)),
                               8'($urandom));
                  default: send_item(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                                     3'($urandom), 8'($urandom));
               endcase
            end
         end
      end
   endtask

   // receiver holds off while the sender keeps pushing refreshes
   task automatic test_output_backpressure();
      wait_idle();
      hold_request = 1'b1;
      burst_left = 1000;
      for (int i = 0; i < 30; i++)
         send_item(REQ_SEGMENT, 3'($urandom_range(0, DIGITS - 1)), 8'($urandom));
      burst_left = 0;
   endtask

   initial begin
      foreach (digits[i]) digits[i] = 8'h00;
      key_bits = '0;
      brightness = 3'd0;
      display_enable = 1'b0;
      flipped = 1'b0;
      mode_code = 2'd3;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_sweep();
      test_random_traffic();
      test_output_backpressure();
      lower_push();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("FAIL");
      $finish;
   end

endmodule
